// ----- sv/mdpd_pkg.sv -----
package mdpd_pkg;

   localparam int PRESSES       = 5;
   localparam int TICK_WIDTH_DEF = 16;
   localparam int CFG_WIDTH     = 16;
   localparam int COUNT_WIDTH   = 3;

   localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd8191;
   localparam logic [CFG_WIDTH-1:0] MIN_RESET     = 16'd128;

   // configuration register indexes
   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_MIN     = 1'b1;

   // fault codes
   localparam logic [1:0] FAULT_OK       = 2'd0;
   localparam logic [1:0] FAULT_PATTERN  = 2'd1;
   localparam logic [1:0] FAULT_TIMEOUT  = 2'd2;
   localparam logic [1:0] FAULT_OVERFLOW = 2'd3;

   typedef enum logic [1:0] {
      EMIT_DECODE,
      EMIT_TIMEOUT,
      EMIT_OVERFLOW
   } emit_type;

   typedef struct packed {
      logic     edge_step;
      logic     advance;
      logic     scan_clear;
      logic     scan_step;
      logic     emit;
      emit_type emit_kind;
   } cmd_type;

   typedef struct packed {
      logic overflow;
      logic timeout;
      logic count_zero;
      logic count_full;
      logic scan_last;
      logic out_free;
   } status_type;

   // pattern: first press in the top bit, 1 = dash
   function automatic logic [3:0] decode_digit(input logic [PRESSES-1:0] pattern);
      logic [3:0] d;
      case (pattern)
         5'h0F:   d = 4'd1;
         5'h07:   d = 4'd2;
         5'h03:   d = 4'd3;
         5'h01:   d = 4'd4;
         5'h1F:   d = 4'd5;
         5'h00:   d = 4'd5;
         5'h10:   d = 4'd6;
         5'h18:   d = 4'd7;
         5'h1C:   d = 4'd8;
         5'h1E:   d = 4'd9;
         default: d = 4'd0;
      endcase
      return d;
   endfunction

endpackage

// ----- sv/mdpd_ctrl.sv -----
module mdpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mdpd_pkg::status_type status,
   output mdpd_pkg::cmd_type    cmd
);
   import mdpd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_SCAN,
      S_JUDGE,
      S_FAULT
   } state_type;

   state_type state_ff, state_in;
   emit_type  kind_ff, kind_in;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      cmd            = '0;
      cmd.emit_kind  = EMIT_DECODE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.edge_step = 1'b1;
               state_in      = S_TICK;
            end
         end
         S_TICK: begin
            if (status.overflow) begin
               kind_in  = EMIT_OVERFLOW;
               state_in = S_FAULT;
            end else begin
               cmd.advance = 1'b1;
               if (!status.timeout || status.count_zero) begin
                  state_in = S_IDLE;
               end else if (status.count_full) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  kind_in  = EMIT_TIMEOUT;
                  state_in = S_FAULT;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_JUDGE;
            end
         end
         S_JUDGE: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_DECODE;
               state_in      = S_IDLE;
            end
         end
         S_FAULT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = kind_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= EMIT_DECODE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ----- sv/mdpd_dpath.sv -----
module mdpd_dpath #(
   parameter int TICK_WIDTH = mdpd_pkg::TICK_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 key_down,
   input  logic                                 csr_valid,
   input  logic                                 csr_index,
   input  logic [mdpd_pkg::CFG_WIDTH-1:0]       csr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [3:0]                           rsp_digit,
   output logic [1:0]                           rsp_fault,
   input  mdpd_pkg::cmd_type                    cmd,
   output mdpd_pkg::status_type                 status
);
   import mdpd_pkg::*;

   localparam int LW = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

   logic [CFG_WIDTH-1:0]   timeout_ff, timeout_in;
   logic [CFG_WIDTH-1:0]   min_ff, min_in;
   logic [TICK_WIDTH-1:0]  elapsed_ff, elapsed_in;
   logic                   key_state_ff, key_state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   logic [TICK_WIDTH-1:0]  len_ff [PRESSES];
   logic [COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic [TICK_WIDTH-1:0]  longest_ff, longest_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [3:0]             digit_ff, digit_in;
   logic [1:0]             fault_ff, fault_in;

   logic                   restart, release_rec, too_many, store_len;
   logic [TICK_WIDTH-1:0]  bumped;
   logic [LW-1:0]          limit;
   logic [TICK_WIDTH-1:0]  half;
   logic [PRESSES-1:0]     pattern;
   logic [3:0]             digit_dec;

   // edge handling
   always_comb begin
      restart     = (key_down != key_state_ff) && (LW'(elapsed_ff) >= LW'(min_ff));
      release_rec = restart && !key_down;
      too_many    = release_rec && (count_ff >= COUNT_WIDTH'(PRESSES));
      store_len   = cmd.edge_step && release_rec && !too_many;
   end

   // counter advance and timeout test, full scale caps the limit
   always_comb begin
      bumped = (elapsed_ff != TICK_MAX) ? elapsed_ff + TICK_WIDTH'(1) : elapsed_ff;
      limit  = (LW'(timeout_ff) > LW'(TICK_MAX)) ? LW'(TICK_MAX) : LW'(timeout_ff);
   end

   // dash when longer than half the longest press
   always_comb begin
      half = longest_ff >> 1;
      for (int k = 0; k < PRESSES; k++) begin
         pattern[PRESSES-1-k] = (len_ff[k] > half);
      end
      digit_dec = decode_digit(pattern);
   end

   always_comb begin
      status.overflow   = overflow_ff;
      status.timeout    = (LW'(bumped) >= limit);
      status.count_zero = (count_ff == '0);
      status.count_full = (count_ff == COUNT_WIDTH'(PRESSES));
      status.scan_last  = (idx_ff == COUNT_WIDTH'(PRESSES - 1));
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      timeout_in   = timeout_ff;
      min_in       = min_ff;
      elapsed_in   = elapsed_ff;
      key_state_in = key_state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      idx_in       = idx_ff;
      longest_in   = longest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      digit_in     = digit_ff;
      fault_in     = fault_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_data;
            CSR_MIN:     min_in     = csr_data;
            default:     ;
         endcase
      end

      if (cmd.edge_step) begin
         key_state_in = key_down;
         overflow_in  = too_many;
         if (restart) begin
            elapsed_in = '0;
         end
         if (too_many) begin
            count_in = '0;
         end else if (release_rec) begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end
      end

      if (cmd.advance) begin
         elapsed_in = status.timeout ? '0 : bumped;
      end

      if (cmd.scan_clear) begin
         idx_in = '0;
      end else if (cmd.scan_step) begin
         if (idx_ff == '0 || len_ff[idx_ff] > longest_ff) begin
            longest_in = len_ff[idx_ff];
         end
         idx_in = idx_ff + COUNT_WIDTH'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         count_in     = '0;
         case (cmd.emit_kind)
            EMIT_DECODE: begin
               digit_in = digit_dec;
               fault_in = (digit_dec == 4'd0) ? FAULT_PATTERN : FAULT_OK;
            end
            EMIT_TIMEOUT: begin
               digit_in = 4'd0;
               fault_in = FAULT_TIMEOUT;
            end
            EMIT_OVERFLOW: begin
               digit_in = 4'd0;
               fault_in = FAULT_OVERFLOW;
            end
            default: begin
               digit_in = 4'd0;
               fault_in = FAULT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         min_ff       <= MIN_RESET;
         elapsed_ff   <= '0;
         key_state_ff <= 1'b0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         min_ff       <= min_in;
         elapsed_ff   <= elapsed_in;
         key_state_ff <= key_state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      longest_ff <= longest_in;
      digit_ff   <= digit_in;
      fault_ff   <= fault_in;
      if (store_len) begin
         len_ff[count_ff] <= elapsed_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_digit  = digit_ff;
   assign rsp_fault  = fault_ff;

endmodule

// ----- sv/morse_digit_press_decoder.sv -----
// A request is accepted only in idle; the tick state then advances the counter and,
// with no result, returns to idle, else a fault state loads a fault result, or,
// after five presses, a scan of the stored lengths (one stored length scanned per
// cycle) and a judge state load the decoded digit; a held result stalls.
// Reset (synchronous, active high) clears counter, key state, press count and
// the pending result, and loads timeout_ticks 8191 and min_ticks 128.
module morse_digit_press_decoder #(
   parameter int TICK_WIDTH = mdpd_pkg::TICK_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel: one timer tick
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [0] key_down, [7:1] zero
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // [3:0] digit, [5:4] fault, [7:6] zero
   // configuration writes: index 0 timeout_ticks, index 1 min_ticks
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [mdpd_pkg::CFG_WIDTH-1:0] csr_data
);
   import mdpd_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [3:0] rsp_digit;
   logic [1:0] rsp_fault;

   // configuration writes land at once; the user must write only while the block is idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // sequencer: edge step, counter advance, longest-press scan, result load
   mdpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // counter, key state, press lengths, config registers and result register
   mdpd_dpath #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .key_down   (req_tdata[0]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_digit  (rsp_digit),
      .rsp_fault  (rsp_fault),
      .cmd        (cmd),
      .status     (status)
   );

   // pack the result: digit low, fault above, pad to a byte
   assign rsp_tdata = {2'b00, rsp_fault, rsp_digit};

endmodule
